[rtl/bpb_pkg.sv]
// bpb_pkg: shared types and codes for the path bounding box block.
// Used by bpb_ctrl, bpb_datapath and the top level. No dependencies.
package bpb_pkg;

  // segment kinds
  localparam logic [1:0] VERB_MOVE  = 2'd0;
  localparam logic [1:0] VERB_LINE  = 2'd1;
  localparam logic [1:0] VERB_QUAD  = 2'd2;
  localparam logic [1:0] VERB_CUBIC = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_AXIS, S_LO_GO, S_LO_W, S_HI_GO, S_HI_W, S_LOOP, S_MID_W,
    S_FOUND, S_NONE, S_PX_GO, S_PX_W, S_PY_GO, S_PY_W, S_PIECE,
    S_ADD_A, S_ADD_B, S_DONE
  } bpb_state_t;

  // coefficient set fed to the evaluator
  typedef enum logic [1:0] {SRC_H, SRC_G, SRC_PX, SRC_PY} bpb_src_t;
  // parameter value fed to the evaluator
  typedef enum logic [1:0] {TSEL_LO, TSEL_HI, TSEL_MID, TSEL_ROOT} bpb_tsel_t;
  // what the root register takes
  typedef enum logic [1:0] {ROOT_KEEP, ROOT_LO, ROOT_HI, ROOT_MID} bpb_root_t;
  // point added to the box
  typedef enum logic [1:0] {ADD_NONE, ADD_P0, ADD_END, ADD_EVAL} bpb_add_t;

  typedef struct packed {
    logic      ld_item;
    logic      eval_go;
    bpb_src_t  src;
    bpb_tsel_t tsel;
    logic      set_slo;
    bpb_root_t root_sel;
    logic      move_lo;
    logic      move_hi;
    logic      start_search;
    logic      pieces_found;
    logic      pieces_none;
    logic      next_piece;
    logic      axis_next;
    logic      hold_x;
    bpb_add_t  add_sel;
    logic      emit;
  } bpb_cmd_t;

  typedef struct packed {
    logic       eval_done;
    logic       res_zero;
    logic       sign_eq;
    logic       span_gt1;
    logic       mode_g;
    logic       split;
    logic       piece;
    logic       axis;
    logic [1:0] verb;
    logic       last;
    logic       out_free;
  } bpb_status_t;

endpackage

[rtl/bpb_channels.sv]
// Request and result channel interfaces of the bounding box block.
// Depends on nothing; width follows COORD_WIDTH.
interface bpb_in_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    verb;
  logic signed [COORD_WIDTH-1:0] p0_x;
  logic signed [COORD_WIDTH-1:0] p0_y;
  logic signed [COORD_WIDTH-1:0] p1_x;
  logic signed [COORD_WIDTH-1:0] p1_y;
  logic signed [COORD_WIDTH-1:0] p2_x;
  logic signed [COORD_WIDTH-1:0] p2_y;
  logic signed [COORD_WIDTH-1:0] p3_x;
  logic signed [COORD_WIDTH-1:0] p3_y;
  logic                          last_segment;
  modport source (output valid, verb, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                  last_segment, input ready);
  modport sink (input valid, verb, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                last_segment, output ready);
endinterface

interface bpb_out_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] min_x;
  logic signed [COORD_WIDTH-1:0] min_y;
  logic signed [COORD_WIDTH-1:0] max_x;
  logic signed [COORD_WIDTH-1:0] max_y;
  modport source (output valid, min_x, min_y, max_x, max_y, input ready);
  modport sink (input valid, min_x, min_y, max_x, max_y, output ready);
endinterface

[rtl/bezier_path_bounds_unit.sv]
// bezier_path_bounds_unit: top level of the path tight bounding box block.
// Depends on bpb_pkg, bpb_channels, bpb_ctrl, bpb_datapath, bpb_eval.
//
// Usage
//  - in_if carries one path segment per request: verb (move, line, quad,
//    cubic), four signed fixed-point points and last_segment.
//  - out_if carries one box (min_x, min_y, max_x, max_y) after each request
//    that has last_segment set; other requests return nothing.
//  - The first request after reset or after an emitted box seeds the box
//    with its first point. Curves add the curve points at the derivative
//    zeros per axis, found by bisection on the hodograph.
// Timing
//  - One request at a time. Curves are bound by the single shared de
//    Casteljau evaluator: one evaluation performs L = 1, 3 or 6 lerps for
//    degree 1, 2 or 3, and a root search takes up to FRAC_BITS + 2
//    evaluations.
//  - The result sits in an output register; the next request is accepted
//    while it waits. Only a second last_segment request stalls, at its end,
//    until the receiver takes the pending box.
//  - Synchronous active-low reset empties the box and drops any result.
module bezier_path_bounds_unit
  import bpb_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  bpb_in_if.sink    in_if,
  bpb_out_if.source out_if
);
  bpb_cmd_t    cmd;
  bpb_status_t status;

  bpb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .status   (status),
    .cmd      (cmd)
  );

  bpb_datapath #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_verb   (in_if.verb),
    .in_p0_x   (in_if.p0_x),
    .in_p0_y   (in_if.p0_y),
    .in_p1_x   (in_if.p1_x),
    .in_p1_y   (in_if.p1_y),
    .in_p2_x   (in_if.p2_x),
    .in_p2_y   (in_if.p2_y),
    .in_p3_x   (in_if.p3_x),
    .in_p3_y   (in_if.p3_y),
    .in_last   (in_if.last_segment),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .out_min_x (out_if.min_x),
    .out_min_y (out_if.min_y),
    .out_max_x (out_if.max_x),
    .out_max_y (out_if.max_y)
  );
endmodule

[rtl/bpb_eval.sv]
// bpb_eval: serial de Casteljau evaluator, one lerp at a time.
// Depends on nothing but its ports.
module bpb_eval #(
  parameter int IW = 36,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [1:0]            deg,
  input  logic [FRAC_BITS:0]    t,
  input  logic signed [IW-1:0]  c0,
  input  logic signed [IW-1:0]  c1,
  input  logic signed [IW-1:0]  c2,
  input  logic signed [IW-1:0]  c3,
  output logic                  done,
  output logic signed [IW-1:0]  result
);
  localparam int PW = IW + FRAC_BITS + 3;

  logic signed [IW-1:0] w0_r, w1_r, w2_r, w3_r;
  logic signed [PW-1:0] prod_r;
  logic [FRAC_BITS:0]   t_r;
  logic [1:0]           k_r, i_r;
  logic                 busy_r, ph_r, done_r;
  logic signed [IW:0]   diff;
  logic signed [IW-1:0] step;
  logic signed [IW-1:0] cur;
  logic signed [PW-1:0] shifted;

  always_comb begin
    case (i_r)
      2'd0: begin
        diff = {w1_r[IW-1], w1_r} - {w0_r[IW-1], w0_r};
        cur  = w0_r;
      end
      2'd1: begin
        diff = {w2_r[IW-1], w2_r} - {w1_r[IW-1], w1_r};
        cur  = w1_r;
      end
      default: begin
        diff = {w3_r[IW-1], w3_r} - {w2_r[IW-1], w2_r};
        cur  = w2_r;
      end
    endcase
  end

  assign shifted = prod_r >>> FRAC_BITS;
  assign step    = cur + shifted[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= 1'b0;
        k_r    <= deg;
        i_r    <= '0;
      end else if (busy_r) begin
        ph_r <= ~ph_r;
        if (ph_r) begin
          if (i_r == k_r - 2'd1) begin
            i_r <= '0;
            if (k_r == 2'd1) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end else begin
              k_r <= k_r - 2'd1;
            end
          end else begin
            i_r <= i_r + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w0_r <= c0;
      w1_r <= c1;
      w2_r <= c2;
      w3_r <= c3;
      t_r  <= t;
    end else if (busy_r) begin
      if (!ph_r) begin
        prod_r <= PW'(diff * $signed({1'b0, t_r}));
      end else begin
        case (i_r)
          2'd0:    w0_r <= step;
          2'd1:    w1_r <= step;
          default: w2_r <= step;
        endcase
      end
    end
  end

  assign done   = done_r;
  assign result = w0_r;
endmodule

[rtl/bpb_datapath.sv]
// bpb_datapath: item registers, box, root search registers, result register.
// Depends on bpb_pkg and bpb_eval.
module bpb_datapath
  import bpb_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bpb_cmd_t                      cmd,
  output bpb_status_t                   status,
  input  logic [1:0]                    in_verb,
  input  logic signed [COORD_WIDTH-1:0] in_p0_x,
  input  logic signed [COORD_WIDTH-1:0] in_p0_y,
  input  logic signed [COORD_WIDTH-1:0] in_p1_x,
  input  logic signed [COORD_WIDTH-1:0] in_p1_y,
  input  logic signed [COORD_WIDTH-1:0] in_p2_x,
  input  logic signed [COORD_WIDTH-1:0] in_p2_y,
  input  logic signed [COORD_WIDTH-1:0] in_p3_x,
  input  logic signed [COORD_WIDTH-1:0] in_p3_y,
  input  logic                          in_last,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_min_x,
  output logic signed [COORD_WIDTH-1:0] out_min_y,
  output logic signed [COORD_WIDTH-1:0] out_max_x,
  output logic signed [COORD_WIDTH-1:0] out_max_y
);
  localparam int W  = COORD_WIDTH;
  localparam int IW = COORD_WIDTH + 4;
  localparam int TW = FRAC_BITS + 1;
  localparam logic [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;

  logic signed [W-1:0] px_r [4];
  logic signed [W-1:0] py_r [4];
  logic [1:0]          verb_r;
  logic                last_r;

  logic signed [W-1:0] bmin_x_r, bmin_y_r, bmax_x_r, bmax_y_r;
  logic                seeded_r;

  logic [TW-1:0] lo_r, hi_r, root_r, tv_r;
  logic          slo_neg_r, mode_g_r, split_r, piece_r, axis_r;
  logic signed [W-1:0] x_r;

  logic                 out_valid_r;
  logic signed [W-1:0]  omin_x_r, omin_y_r, omax_x_r, omax_y_r;

  logic signed [IW-1:0] ax [4];
  logic signed [IW-1:0] h0, h1, h2, g0, g1;
  logic signed [IW-1:0] c0, c1, c2, c3;
  logic [1:0]           deg;
  logic [TW-1:0]        tval, mid, span;
  logic                 split_ok;
  logic signed [IW-1:0] res;
  logic                 ev_done;
  logic signed [W-1:0]  add_x, add_y;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ax[k] = axis_r ? IW'(py_r[k]) : IW'(px_r[k]);
    end
  end

  assign h0 = ax[1] - ax[0];
  assign h1 = ax[2] - ax[1];
  assign h2 = ax[3] - ax[2];
  assign g0 = h1 - h0;
  assign g1 = h2 - h1;

  always_comb begin
    case (cmd.src)
      SRC_H: begin
        c0 = h0; c1 = h1; c2 = h2; c3 = '0;
        deg = verb_r - 2'd1;
      end
      SRC_G: begin
        c0 = g0; c1 = g1; c2 = '0; c3 = '0;
        deg = 2'd1;
      end
      SRC_PX: begin
        c0 = IW'(px_r[0]); c1 = IW'(px_r[1]); c2 = IW'(px_r[2]); c3 = IW'(px_r[3]);
        deg = verb_r;
      end
      default: begin
        c0 = IW'(py_r[0]); c1 = IW'(py_r[1]); c2 = IW'(py_r[2]); c3 = IW'(py_r[3]);
        deg = verb_r;
      end
    endcase
  end

  assign span = hi_r - lo_r;
  assign mid  = lo_r + (span >> 1);

  always_comb begin
    case (cmd.tsel)
      TSEL_LO:  tval = lo_r;
      TSEL_HI:  tval = hi_r;
      TSEL_MID: tval = mid;
      default:  tval = root_r;
    endcase
  end

  bpb_eval #(.IW(IW), .FRAC_BITS(FRAC_BITS)) u_eval (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.eval_go),
    .deg    (deg),
    .t      (tval),
    .c0     (c0),
    .c1     (c1),
    .c2     (c2),
    .c3     (c3),
    .done   (ev_done),
    .result (res)
  );

  assign split_ok = (root_r != '0) && (root_r != T_ONE);

  // point picked for the box update
  always_comb begin
    case (cmd.add_sel)
      ADD_P0: begin
        add_x = px_r[0]; add_y = py_r[0];
      end
      ADD_END: begin
        case (verb_r)
          VERB_LINE: begin add_x = px_r[1]; add_y = py_r[1]; end
          VERB_QUAD: begin add_x = px_r[2]; add_y = py_r[2]; end
          default:   begin add_x = px_r[3]; add_y = py_r[3]; end
        endcase
      end
      default: begin
        add_x = x_r; add_y = res[W-1:0];
      end
    endcase
  end

  // item and search registers
  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      px_r[0] <= in_p0_x; py_r[0] <= in_p0_y;
      px_r[1] <= in_p1_x; py_r[1] <= in_p1_y;
      px_r[2] <= in_p2_x; py_r[2] <= in_p2_y;
      px_r[3] <= in_p3_x; py_r[3] <= in_p3_y;
    end
    if (cmd.hold_x) x_r <= res[W-1:0];
    if (cmd.set_slo) slo_neg_r <= res[IW-1];
    case (cmd.root_sel)
      ROOT_LO:  root_r <= lo_r;
      ROOT_HI:  root_r <= hi_r;
      ROOT_MID: root_r <= mid;
      default:  root_r <= root_r;
    endcase
    if (cmd.move_lo) lo_r <= mid;
    if (cmd.move_hi) hi_r <= mid;
    if (cmd.start_search || cmd.pieces_none) begin
      lo_r <= '0;
      hi_r <= T_ONE;
    end
    if (cmd.pieces_found) begin
      tv_r <= root_r;
      lo_r <= '0;
      hi_r <= split_ok ? root_r : T_ONE;
    end
    if (cmd.next_piece) begin
      lo_r <= tv_r;
      hi_r <= T_ONE;
    end
  end

  // control flags and box
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      verb_r      <= VERB_MOVE;
      last_r      <= 1'b0;
      seeded_r    <= 1'b0;
      bmin_x_r    <= '0;
      bmin_y_r    <= '0;
      bmax_x_r    <= '0;
      bmax_y_r    <= '0;
      mode_g_r    <= 1'b0;
      split_r     <= 1'b0;
      piece_r     <= 1'b0;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit)                     out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.ld_item) begin
        verb_r <= in_verb;
        last_r <= in_last;
        axis_r <= 1'b0;
        if (!seeded_r) begin
          seeded_r <= 1'b1;
          bmin_x_r <= in_p0_x; bmax_x_r <= in_p0_x;
          bmin_y_r <= in_p0_y; bmax_y_r <= in_p0_y;
        end
      end
      if (cmd.start_search) begin
        mode_g_r <= (verb_r == VERB_CUBIC);
        split_r  <= 1'b0;
        piece_r  <= 1'b0;
      end
      if (cmd.pieces_found) begin
        mode_g_r <= 1'b0;
        split_r  <= split_ok;
      end
      if (cmd.pieces_none) begin
        mode_g_r <= 1'b0;
        split_r  <= 1'b0;
      end
      if (cmd.next_piece) piece_r <= 1'b1;
      if (cmd.axis_next) axis_r <= 1'b1;
      if (cmd.add_sel != ADD_NONE) begin
        if (add_x < bmin_x_r) bmin_x_r <= add_x;
        if (add_x > bmax_x_r) bmax_x_r <= add_x;
        if (add_y < bmin_y_r) bmin_y_r <= add_y;
        if (add_y > bmax_y_r) bmax_y_r <= add_y;
      end
      if (cmd.emit) begin
        seeded_r    <= 1'b0;
        bmin_x_r    <= '0;
        bmin_y_r    <= '0;
        bmax_x_r    <= '0;
        bmax_y_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      omin_x_r <= seeded_r ? bmin_x_r : '0;
      omin_y_r <= seeded_r ? bmin_y_r : '0;
      omax_x_r <= seeded_r ? bmax_x_r : '0;
      omax_y_r <= seeded_r ? bmax_y_r : '0;
    end
  end

  assign status.eval_done = ev_done;
  assign status.res_zero  = (res == '0);
  assign status.sign_eq   = (res[IW-1] == slo_neg_r);
  assign status.span_gt1  = (span > TW'(1));
  assign status.mode_g    = mode_g_r;
  assign status.split     = split_r;
  assign status.piece     = piece_r;
  assign status.axis      = axis_r;
  // kind of the incoming segment, read by the sequencer in idle
  assign status.verb      = in_verb;
  assign status.last      = last_r;
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_min_x = omin_x_r;
  assign out_min_y = omin_y_r;
  assign out_max_x = omax_x_r;
  assign out_max_y = omax_y_r;
endmodule

[rtl/bpb_ctrl.sv]
// bpb_ctrl: sequencer for segment handling and per-axis root search.
// Depends on bpb_pkg.
module bpb_ctrl
  import bpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  bpb_status_t status,
  output bpb_cmd_t    cmd
);
  bpb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:
        if (in_valid) begin
          // segment kind decides the path out of idle
          case (status.verb)
            VERB_MOVE: state_nxt = S_DONE;
            VERB_LINE: state_nxt = S_ADD_A;
            default:   state_nxt = S_AXIS;
          endcase
        end
      S_AXIS:  state_nxt = S_LO_GO;
      S_LO_GO: state_nxt = S_LO_W;
      S_LO_W:
        if (status.eval_done) begin
          state_nxt = status.res_zero ? S_FOUND : S_HI_GO;
        end
      S_HI_GO: state_nxt = S_HI_W;
      S_HI_W:
        if (status.eval_done) begin
          if (status.res_zero)     state_nxt = S_FOUND;
          else if (status.sign_eq) state_nxt = S_NONE;
          else                     state_nxt = S_LOOP;
        end
      S_LOOP:  state_nxt = status.span_gt1 ? S_MID_W : S_FOUND;
      S_MID_W:
        if (status.eval_done) begin
          state_nxt = status.res_zero ? S_FOUND : S_LOOP;
        end
      S_FOUND: state_nxt = status.mode_g ? S_LO_GO : S_PX_GO;
      S_NONE:  state_nxt = status.mode_g ? S_LO_GO : S_PIECE;
      S_PX_GO: state_nxt = S_PX_W;
      S_PX_W:  if (status.eval_done) state_nxt = S_PY_GO;
      S_PY_GO: state_nxt = S_PY_W;
      S_PY_W:  if (status.eval_done) state_nxt = S_PIECE;
      S_PIECE: begin
        if (status.split && !status.piece) state_nxt = S_LO_GO;
        else if (!status.axis)             state_nxt = S_AXIS;
        else                               state_nxt = S_ADD_A;
      end
      S_ADD_A: state_nxt = S_ADD_B;
      S_ADD_B: state_nxt = S_DONE;
      S_DONE:
        if (!status.last)         state_nxt = S_IDLE;
        else if (status.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.src  = status.mode_g ? SRC_G : SRC_H;
    cmd.tsel = TSEL_LO;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.ld_item = in_valid;
      end
      S_AXIS: cmd.start_search = 1'b1;
      S_LO_GO: begin
        cmd.eval_go = 1'b1;
        cmd.tsel    = TSEL_LO;
      end
      S_LO_W:
        if (status.eval_done) begin
          cmd.set_slo = 1'b1;
          if (status.res_zero) cmd.root_sel = ROOT_LO;
        end
      S_HI_GO: begin
        cmd.eval_go = 1'b1;
        cmd.tsel    = TSEL_HI;
      end
      S_HI_W:
        if (status.eval_done && status.res_zero) begin
          cmd.root_sel = ROOT_HI;
        end
      S_LOOP: begin
        if (status.span_gt1) begin
          cmd.eval_go = 1'b1;
          cmd.tsel    = TSEL_MID;
        end else begin
          cmd.root_sel = ROOT_LO;
        end
      end
      S_MID_W: begin
        cmd.tsel = TSEL_MID;
        if (status.eval_done) begin
          if (status.res_zero)     cmd.root_sel = ROOT_MID;
          else if (status.sign_eq) cmd.move_lo  = 1'b1;
          else                     cmd.move_hi  = 1'b1;
        end
      end
      S_FOUND: cmd.pieces_found = status.mode_g;
      S_NONE:  cmd.pieces_none  = status.mode_g;
      S_PX_GO: begin
        cmd.eval_go = 1'b1;
        cmd.src     = SRC_PX;
        cmd.tsel    = TSEL_ROOT;
      end
      S_PX_W: cmd.hold_x = status.eval_done;
      S_PY_GO: begin
        cmd.eval_go = 1'b1;
        cmd.src     = SRC_PY;
        cmd.tsel    = TSEL_ROOT;
      end
      S_PY_W:
        if (status.eval_done) cmd.add_sel = ADD_EVAL;
      S_PIECE: begin
        if (status.split && !status.piece) cmd.next_piece = 1'b1;
        else if (!status.axis)             cmd.axis_next  = 1'b1;
      end
      S_ADD_A: cmd.add_sel = ADD_P0;
      S_ADD_B: cmd.add_sel = ADD_END;
      S_DONE:  cmd.emit = status.last && status.out_free;
      default: cmd = '0;
    endcase
  end
endmodule

[tb/sv/tb_bezier_path_bounds.sv]
// tb: self-checking testbench for bezier_path_bounds_unit.
// Depends on bpb_pkg, bpb_channels and the block's RTL.
module tb;
  import bpb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam longint T_FULL = 64'd1 << FB;
  // watchdog limit; covers the slowest cubic plus receiver stalls
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [1:0]     verb;
    logic [CW-1:0]  px[4];
    logic [CW-1:0]  py[4];
    logic           last;
  } segment_t;

  typedef struct {
    logic [CW-1:0] min_x, min_y, max_x, max_y;
  } box_t;

  logic clk;
  logic rst_n;

  bpb_in_if  #(.COORD_WIDTH(CW)) in_ch ();
  bpb_out_if #(.COORD_WIDTH(CW)) out_ch ();

  bezier_path_bounds_unit #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) uut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Predictor state: the running box and whether it has been seeded.
  longint acc_min_x, acc_min_y, acc_max_x, acc_max_y;
  bit     acc_seeded;
  box_t   box_queue[$];

  int  errors;
  int  boxes_checked;
  int  segs_sent;
  int  idle_in_pct, stall_out_pct;
  int  quiet_cycles;
  int  verb_count[4];

  // floor(d * t / 2^FB) by shift-add; equals the hardware's multiply and shift
  function automatic longint frac_mul(longint d, longint t);
    longint acc;
    acc = 0;
    for (int i = 0; i < FB; i++) begin
      if (t[i]) acc += d;
      acc = acc >>> 1;
    end
    if (t[FB]) acc += d;
    return acc;
  endfunction

  // de Casteljau evaluation of a degree 1..3 curve
  function automatic longint casteljau(longint c[4], int deg, longint t);
    longint w[4];
    w = c;
    for (int k = deg; k > 0; k--)
      for (int i = 0; i < k; i++)
        w[i] = w[i] + frac_mul(w[i+1] - w[i], t);
    return w[0];
  endfunction

  function automatic int sign_of(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // bisection root search on a monotone piece [lo,hi]
  function automatic bit bisect_root(longint c[4], int deg, longint lo, longint hi,
                                     output longint t);
    int s_lo, s_hi, s;
    longint mid;
    s_lo = sign_of(casteljau(c, deg, lo));
    s_hi = sign_of(casteljau(c, deg, hi));
    t = lo;
    if (s_lo == 0) return 1;
    if (s_hi == 0) begin t = hi; return 1; end
    if (s_lo == s_hi) return 0;
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >> 1);
      s = sign_of(casteljau(c, deg, mid));
      if (s == 0) begin t = mid; return 1; end
      if (s == s_lo) lo = mid;
      else hi = mid;
    end
    t = lo;
    return 1;
  endfunction

  function automatic void grow_box(longint x, longint y);
    if (x < acc_min_x) acc_min_x = x;
    if (x > acc_max_x) acc_max_x = x;
    if (y < acc_min_y) acc_min_y = y;
    if (y > acc_max_y) acc_max_y = y;
  endfunction

  // Folds one segment into the running box; pushes a box on last_segment.
  function automatic void fold_segment(segment_t s);
    longint x[4], y[4], ax[4], h[4], g[4], t, tv;
    longint lo[2], hi[2];
    int pieces;
    box_t b;
    for (int i = 0; i < 4; i++) begin
      x[i] = longint'($signed(s.px[i]));
      y[i] = longint'($signed(s.py[i]));
    end
    if (!acc_seeded) begin
      acc_min_x = x[0]; acc_max_x = x[0];
      acc_min_y = y[0]; acc_max_y = y[0];
      acc_seeded = 1;
    end
    case (s.verb)
      VERB_LINE: begin
        grow_box(x[0], y[0]);
        grow_box(x[1], y[1]);
      end
      VERB_QUAD: begin
        for (int a = 0; a < 2; a++) begin
          for (int i = 0; i < 4; i++) ax[i] = (a == 0) ? x[i] : y[i];
          h = '{ax[1] - ax[0], ax[2] - ax[1], 0, 0};
          if (bisect_root(h, 1, 0, T_FULL, t))
            grow_box(casteljau(x, 2, t), casteljau(y, 2, t));
        end
        grow_box(x[0], y[0]);
        grow_box(x[2], y[2]);
      end
      VERB_CUBIC: begin
        for (int a = 0; a < 2; a++) begin
          for (int i = 0; i < 4; i++) ax[i] = (a == 0) ? x[i] : y[i];
          h = '{ax[1] - ax[0], ax[2] - ax[1], ax[3] - ax[2], 0};
          g = '{h[1] - h[0], h[2] - h[1], 0, 0};
          lo[0] = 0; hi[0] = T_FULL; pieces = 1;
          // split the hodograph at its own turning point
          if (bisect_root(g, 1, 0, T_FULL, tv) && tv > 0 && tv < T_FULL) begin
            hi[0] = tv; lo[1] = tv; hi[1] = T_FULL; pieces = 2;
          end
          for (int k = 0; k < pieces; k++)
            if (bisect_root(h, 2, lo[k], hi[k], t))
              grow_box(casteljau(x, 3, t), casteljau(y, 3, t));
        end
        grow_box(x[0], y[0]);
        grow_box(x[3], y[3]);
      end
      default: ;  // a move only seeds
    endcase
    if (s.last) begin
      b.min_x = acc_min_x[CW-1:0]; b.min_y = acc_min_y[CW-1:0];
      b.max_x = acc_max_x[CW-1:0]; b.max_y = acc_max_y[CW-1:0];
      box_queue.push_back(b);
      acc_seeded = 0;
      acc_min_x = 0; acc_min_y = 0; acc_max_x = 0; acc_max_y = 0;
    end
  endfunction

  // Sends one request; random idle cycles first, then waits for ready.
  // Valid stays up between back-to-back requests.
  task automatic send_segment(segment_t s);
    if ($urandom_range(99) < idle_in_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_in_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.verb <= s.verb;
    in_ch.p0_x <= s.px[0]; in_ch.p0_y <= s.py[0];
    in_ch.p1_x <= s.px[1]; in_ch.p1_y <= s.py[1];
    in_ch.p2_x <= s.px[2]; in_ch.p2_y <= s.py[2];
    in_ch.p3_x <= s.px[3]; in_ch.p3_y <= s.py[3];
    in_ch.last_segment <= s.last;
    do @(posedge clk); while (!in_ch.ready);
    fold_segment(s);
    verb_count[s.verb]++;
    segs_sent++;
  endtask

  // Receiver: random backpressure, checks each accepted box.
  always @(posedge clk) begin
    box_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (box_queue.size() == 0) begin
          $error("unexpected box %h %h %h %h", out_ch.min_x, out_ch.min_y,
                 out_ch.max_x, out_ch.max_y);
          errors++;
        end else begin
          e = box_queue.pop_front();
          if (out_ch.min_x !== e.min_x) begin
            $error("min_x expected %h actual %h", e.min_x, out_ch.min_x); errors++;
          end
          if (out_ch.min_y !== e.min_y) begin
            $error("min_y expected %h actual %h", e.min_y, out_ch.min_y); errors++;
          end
          if (out_ch.max_x !== e.max_x) begin
            $error("max_x expected %h actual %h", e.max_x, out_ch.max_x); errors++;
          end
          if (out_ch.max_y !== e.max_y) begin
            $error("max_y expected %h actual %h", e.max_y, out_ch.max_y); errors++;
          end
          boxes_checked++;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_out_pct);
    end
  end

  // Watchdog: counts cycles with no accepted request or box.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d boxes still pending", box_queue.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Coordinate mix: extremes, small values near zero, 24-bit range, full random.
  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return CW'($signed($urandom_range(4000)) - 2000);
      4, 5: return CW'($signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic segment_t rand_segment(logic [1:0] v, logic last);
    segment_t s;
    s.verb = v;
    s.last = last;
    for (int i = 0; i < 4; i++) begin
      s.px[i] = rand_coord();
      s.py[i] = rand_coord();
    end
    return s;
  endfunction

  function automatic segment_t make_seg(logic [1:0] v, logic last,
                                        longint x0, longint y0, longint x1, longint y1,
                                        longint x2, longint y2, longint x3, longint y3);
    segment_t s;
    s.verb = v; s.last = last;
    s.px = '{x0[CW-1:0], x1[CW-1:0], x2[CW-1:0], x3[CW-1:0]};
    s.py = '{y0[CW-1:0], y1[CW-1:0], y2[CW-1:0], y3[CW-1:0]};
    return s;
  endfunction

  // Directed: extremes, every verb, flat curves, derivative zeros at ends,
  // move-first path, single-move path, double-root cubic.
  task automatic test_directed();
    localparam longint MN = -64'sd2147483648;
    localparam longint MX = 64'sd2147483647;
    localparam longint ONE = 64'sd65536;
    send_segment(make_seg(VERB_MOVE, 1, 5, -7, 1, 2, 3, 4, 5, 6));
    send_segment(make_seg(VERB_MOVE, 0, MN, MX, 0, 0, 0, 0, 0, 0));
    send_segment(make_seg(VERB_MOVE, 0, 0, 0, MX, MN, 0, 0, 0, 0));
    send_segment(make_seg(VERB_LINE, 1, MX, MN, MN, MX, 0, 0, 0, 0));
    send_segment(make_seg(VERB_QUAD, 1, 0, 0, ONE, 2*ONE, 2*ONE, 0, 0, 0));
    send_segment(make_seg(VERB_QUAD, 0, MN, MN, MX, MX, MN, MN, 0, 0));
    send_segment(make_seg(VERB_QUAD, 1, 0, 0, ONE, ONE, 2*ONE, 2*ONE, 0, 0));
    send_segment(make_seg(VERB_QUAD, 1, 0, 0, 0, 0, ONE, ONE, 0, 0));
    send_segment(make_seg(VERB_QUAD, 1, 3, 3, 3, 3, 3, 3, 0, 0));
    send_segment(make_seg(VERB_CUBIC, 1, 0, 0, ONE, 3*ONE, 2*ONE, -3*ONE, 3*ONE, 0));
    send_segment(make_seg(VERB_CUBIC, 1, MN, MX, MX, MN, MN, MX, MX, MN));
    send_segment(make_seg(VERB_CUBIC, 1, 0, 0, ONE, ONE, 2*ONE, 2*ONE, 3*ONE, 3*ONE));
    send_segment(make_seg(VERB_CUBIC, 0, 0, 0, 0, 0, 0, 0, ONE, -ONE));
    send_segment(make_seg(VERB_CUBIC, 1, 0, 0, 2*ONE, ONE, -ONE, ONE, ONE, 0));
    send_segment(make_seg(VERB_CUBIC, 1, 0, 0, 0, 4*ONE, 0, -4*ONE, 0, 0));
    send_segment(make_seg(VERB_LINE, 0, -1, -1, 0, 0, 0, 0, 0, 0));
    send_segment(make_seg(VERB_LINE, 1, -1, -1, -1, -1, 0, 0, 0, 0));
  endtask

  // Random paths: a move, a run of segments, the last one emits.
  // Occasional path without a leading move and stray single items.
  task automatic test_random_paths(int n_items);
    int len;
    int sent;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 8);
      for (int i = 0; i < len; i++) begin
        logic [1:0] v;
        if (i == 0 && $urandom_range(4) != 0) v = VERB_MOVE;
        else if ($urandom_range(9) == 0) v = VERB_MOVE;
        else v = 2'($urandom_range(1, 3));
        send_segment(rand_segment(v, i == len - 1));
        sent++;
      end
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (box_queue.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    errors = 0; boxes_checked = 0; segs_sent = 0; quiet_cycles = 0;
    verb_count = '{0, 0, 0, 0};
    acc_seeded = 0; acc_min_x = 0; acc_min_y = 0; acc_max_x = 0; acc_max_y = 0;
    idle_in_pct = 30; stall_out_pct = 53;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.verb = VERB_MOVE; in_ch.last_segment = 1'b0;
    in_ch.p0_x = '0; in_ch.p0_y = '0; in_ch.p1_x = '0; in_ch.p1_y = '0;
    in_ch.p2_x = '0; in_ch.p2_y = '0; in_ch.p3_x = '0; in_ch.p3_y = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_paths(480);
    idle_in_pct = 53; stall_out_pct = 30;
    test_random_paths(480);
    idle_in_pct = 0; stall_out_pct = 0;
    test_random_paths(480);
    wait_drained();

    $display("sent %0d requests (move %0d line %0d quad %0d cubic %0d)",
             segs_sent, verb_count[0], verb_count[1], verb_count[2], verb_count[3]);
    $display("checked %0d boxes under three idle/stall mixes", boxes_checked);
    if (errors == 0 && box_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/bpb_pkg.sv
rtl/bpb_channels.sv
rtl/bpb_eval.sv
rtl/bpb_datapath.sv
rtl/bpb_ctrl.sv
rtl/bezier_path_bounds_unit.sv
tb/sv/tb_bezier_path_bounds.sv
